@@ sv/deq_pkg.sv @@
`timescale 1ns / 1ps

package deq_pkg;

   // Default geometry of the store
   localparam int DEPTH_DEFAULT      = 64;
   localparam int DATA_WIDTH_DEFAULT = 32;

   // Operation codes carried in the kind field
   localparam logic [2:0] KIND_PUSH_BACK  = 3'd0;
   localparam logic [2:0] KIND_PUSH_FRONT = 3'd1;
   localparam logic [2:0] KIND_LIST_ALL   = 3'd2;
   localparam logic [2:0] KIND_POP_FRONT  = 3'd3;
   localparam logic [2:0] KIND_POP_BACK   = 3'd4;

   // Status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [2:0]         kind;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] value_res;
      logic [1:0]         status;
      logic               last;
   } rsp_type;

endpackage

@@ sv/deq_store.sv @@
`timescale 1ns / 1ps

module deq_store #(
   parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT,
   parameter int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [IDX_W-1:0]             wr_addr,
   input  logic signed [DATA_WIDTH-1:0] wr_data,
   input  logic                         rd_en,
   input  logic [IDX_W-1:0]             rd_addr,
   output logic signed [DATA_WIDTH-1:0] rd_data
);
   import deq_pkg::*;

   logic signed [DATA_WIDTH-1:0] mem [DEPTH];
   logic signed [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // hold the last read word until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/double_ended_queue_unit.sv @@
`timescale 1ns / 1ps

// Bounded double-ended queue of signed words kept in a ring store of DEPTH
// entries held in one synchronous memory (one write and one read port, read
// data registered). Each request word performs one operation: push at the
// back, push at the front, list all entries from front to back, pop from the
// front or pop from the back. Pushes, error cases (push when full, pop or
// list when empty) and unknown kinds load their result word at the accepting
// edge, so the next request can follow at once while rsp_stall is low. A pop
// stalls the input while the memory is read; its word passes through the
// memory's read register before the result register, later than a push's. A
// list of N entries stalls the input while it issues the first read and then
// one read per cycle while the read data moves out; its N result words follow
// in order with last set on the final one. rsp_stall can hold any of these
// steps. req_stall is high while a pop or list is in progress, and while the
// result register is full and stalled.
// Entries are not cleared at reset; only written entries are ever read back.
module double_ended_queue_unit #(
   parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  deq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output deq_pkg::rsp_type rsp_data
);
   import deq_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = IDX_W + 1;

   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);
   localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(DEPTH);

   // ring pointer and fill level
   logic [IDX_W-1:0] front_ff, front_in;
   logic [CNT_W-1:0] occ_ff, occ_in;

   // pop or list in progress
   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic [IDX_W-1:0] ptr_ff, ptr_in;

   // memory read data is waiting to be moved to the result register
   logic             rd_valid_ff, rd_valid_in;
   logic             rd_last_ff, rd_last_in;

   // result register
   logic             out_valid_ff, out_valid_in;
   rsp_type          out_ff, out_in;

   // memory port
   logic                         wr_en;
   logic [IDX_W-1:0]             wr_addr;
   logic signed [DATA_WIDTH-1:0] wr_data;
   logic                         rd_en;
   logic [IDX_W-1:0]             rd_addr;
   logic signed [DATA_WIDTH-1:0] rd_data;

   logic             out_free;
   logic             accept;
   logic             consume;
   logic             issue;
   logic             is_full;
   logic             is_empty;
   logic [SUM_W-1:0] tail_sum;
   logic [SUM_W-1:0] back_sum;
   logic [IDX_W-1:0] tail_slot;
   logic [IDX_W-1:0] back_slot;
   logic [IDX_W-1:0] front_dec;
   logic [IDX_W-1:0] front_inc;
   logic [IDX_W-1:0] ptr_inc;

   deq_store #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .IDX_W      (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // the result register can take a word when empty or being drained
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign req_stall = busy_ff || !out_free;
   assign accept    = req_valid && !req_stall;

   // move read data out; issue the next list read once the data slot clears
   assign consume = rd_valid_ff && out_free;
   assign issue   = busy_ff && (left_ff != '0) && (!rd_valid_ff || consume);

   assign is_full  = (occ_ff == FULL_CNT);
   assign is_empty = (occ_ff == '0);

   // ring arithmetic: sums stay below twice the depth, so one subtract wraps
   always_comb begin
      tail_sum  = {1'b0, front_ff} + SUM_W'(occ_ff);
      back_sum  = tail_sum - SUM_W'(1);
      tail_slot = (tail_sum >= DEPTH_SUM) ? IDX_W'(tail_sum - DEPTH_SUM)
                                          : IDX_W'(tail_sum);
      back_slot = (back_sum >= DEPTH_SUM) ? IDX_W'(back_sum - DEPTH_SUM)
                                          : IDX_W'(back_sum);
      front_dec = (front_ff == '0) ? LAST_SLOT : front_ff - IDX_W'(1);
      front_inc = (front_ff == LAST_SLOT) ? '0 : front_ff + IDX_W'(1);
      ptr_inc   = (ptr_ff == LAST_SLOT) ? '0 : ptr_ff + IDX_W'(1);
   end

   // keep the low DATA_WIDTH bits of the pushed word, sign-extending if wider
   assign wr_data = DATA_WIDTH'(req_data.value);

   always_comb begin
      front_in     = front_ff;
      occ_in       = occ_ff;
      busy_in      = busy_ff;
      left_in      = left_ff;
      ptr_in       = ptr_ff;
      rd_valid_in  = rd_valid_ff;
      rd_last_in   = rd_last_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      wr_en        = 1'b0;
      wr_addr      = tail_slot;
      rd_en        = 1'b0;
      rd_addr      = ptr_ff;

      // drop the result word once taken
      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end

      // advance read data into the result register
      if (consume) begin
         rd_valid_in         = 1'b0;
         out_valid_in        = 1'b1;
         out_in.value_res    = 32'(rd_data);
         out_in.status       = STATUS_OK;
         out_in.last         = rd_last_ff;
         if (left_ff == '0) begin
            busy_in = 1'b0;
         end
      end

      // stream the list: one read per cycle while the read data keeps moving out
      if (issue) begin
         rd_en       = 1'b1;
         rd_addr     = ptr_ff;
         ptr_in      = ptr_inc;
         left_in     = left_ff - CNT_W'(1);
         rd_valid_in = 1'b1;
         rd_last_in  = (left_ff == CNT_W'(1));
      end

      if (accept) begin
         // default immediate answer; overridden for reads below
         out_valid_in     = 1'b1;
         out_in.value_res = '0;
         out_in.status    = STATUS_OK;
         out_in.last      = 1'b1;
         case (req_data.kind)
            KIND_PUSH_BACK: begin
               if (is_full) begin
                  out_in.status = STATUS_FULL;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = tail_slot;
                  occ_in  = occ_ff + CNT_W'(1);
               end
            end
            KIND_PUSH_FRONT: begin
               if (is_full) begin
                  out_in.status = STATUS_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = front_dec;
                  front_in = front_dec;
                  occ_in   = occ_ff + CNT_W'(1);
               end
            end
            KIND_LIST_ALL: begin
               if (is_empty) begin
                  out_in.status = STATUS_EMPTY;
               end else begin
                  out_valid_in = 1'b0;
                  busy_in      = 1'b1;
                  left_in      = occ_ff;
                  ptr_in       = front_ff;
               end
            end
            KIND_POP_FRONT: begin
               if (is_empty) begin
                  out_in.status = STATUS_EMPTY;
               end else begin
                  out_valid_in = 1'b0;
                  rd_en        = 1'b1;
                  rd_addr      = front_ff;
                  rd_valid_in  = 1'b1;
                  rd_last_in   = 1'b1;
                  busy_in      = 1'b1;
                  left_in      = '0;
                  front_in     = front_inc;
                  occ_in       = occ_ff - CNT_W'(1);
               end
            end
            KIND_POP_BACK: begin
               if (is_empty) begin
                  out_in.status = STATUS_EMPTY;
               end else begin
                  out_valid_in = 1'b0;
                  rd_en        = 1'b1;
                  rd_addr      = back_slot;
                  rd_valid_in  = 1'b1;
                  rd_last_in   = 1'b1;
                  busy_in      = 1'b1;
                  left_in      = '0;
                  occ_in       = occ_ff - CNT_W'(1);
               end
            end
            default: begin
               // unknown kind: no operation, plain OK word
               out_in.status = STATUS_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         occ_ff       <= '0;
         busy_ff      <= 1'b0;
         left_ff      <= '0;
         rd_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         occ_ff       <= occ_in;
         busy_ff      <= busy_in;
         left_ff      <= left_in;
         rd_valid_ff  <= rd_valid_in;
         out_valid_ff <= out_valid_in;
      end
      ptr_ff     <= ptr_in;
      rd_last_ff <= rd_last_in;
      out_ff     <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

@@ bench/deque_checker.sv @@
`timescale 1ns / 1ps

module deque_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  deq_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  deq_pkg::rsp_type rsp_data,
   output int               mismatch_count,
   output int               words_outstanding,
   output int               words_checked
);
   import deq_pkg::*;

   localparam int SLOTS = DEPTH_DEFAULT;

   // Own copy of the ring store
   logic signed [31:0] ring [SLOTS];
   int unsigned        head_slot;
   int unsigned        fill_level;
   rsp_type            due_words [$];
   int                 fails;
   int                 checked;

   function automatic rsp_type result_word(logic signed [31:0] v, logic [1:0] st, logic lst);
      rsp_type w;
      w.value_res = v;
      w.status    = st;
      w.last      = lst;
      return w;
   endfunction

   // Apply one request word to the store and queue the result words it causes
   task automatic apply_deque_op(req_type op);
      int unsigned slot;
      int unsigned i;
      case (op.kind)
         KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
            if (fill_level == SLOTS) begin
               due_words.push_back(result_word('0, STATUS_FULL, 1'b1));
            end else begin
               if (op.kind == KIND_PUSH_BACK) begin
                  slot = (head_slot + fill_level) % SLOTS;
               end else begin
                  head_slot = (head_slot + SLOTS - 1) % SLOTS;
                  slot      = head_slot;
               end
               ring[slot] = op.value;
               fill_level++;
               due_words.push_back(result_word('0, STATUS_OK, 1'b1));
            end
         end
         KIND_LIST_ALL: begin
            if (fill_level == 0) begin
               due_words.push_back(result_word('0, STATUS_EMPTY, 1'b1));
            end else begin
               for (i = 0; i < fill_level; i++) begin
                  slot = (head_slot + i) % SLOTS;
                  due_words.push_back(result_word(ring[slot], STATUS_OK, i + 1 == fill_level));
               end
            end
         end
         KIND_POP_FRONT, KIND_POP_BACK: begin
            if (fill_level == 0) begin
               due_words.push_back(result_word('0, STATUS_EMPTY, 1'b1));
            end else begin
               if (op.kind == KIND_POP_FRONT) begin
                  slot      = head_slot;
                  head_slot = (head_slot + 1) % SLOTS;
               end else begin
                  slot = (head_slot + fill_level - 1) % SLOTS;
               end
               fill_level--;
               due_words.push_back(result_word(ring[slot], STATUS_OK, 1'b1));
            end
         end
         default: begin
            due_words.push_back(result_word('0, STATUS_OK, 1'b1));
         end
      endcase
   endtask

   always @(posedge clock) begin
      rsp_type exp_word;
      if (reset) begin
         head_slot  = 0;
         fill_level = 0;
         due_words.delete();
      end else begin
         if (req_valid && !req_stall) begin
            apply_deque_op(req_data);
         end
         if (rsp_valid && !rsp_stall) begin
            checked++;
            if (due_words.size() == 0) begin
               $error("result word with none awaited: value_res %0d status %0d last %0d",
                      rsp_data.value_res, rsp_data.status, rsp_data.last);
               fails++;
            end else begin
               exp_word = due_words.pop_front();
               if (rsp_data.value_res !== exp_word.value_res) begin
                  $error("value_res: expected %0d, got %0d",
                         exp_word.value_res, rsp_data.value_res);
                  fails++;
               end
               if (rsp_data.status !== exp_word.status) begin
                  $error("status: expected %0d, got %0d", exp_word.status, rsp_data.status);
                  fails++;
               end
               if (rsp_data.last !== exp_word.last) begin
                  $error("last: expected %0d, got %0d", exp_word.last, rsp_data.last);
                  fails++;
               end
            end
         end
      end
      mismatch_count    <= fails;
      words_outstanding <= due_words.size();
      words_checked     <= checked;
   end

endmodule

@@ bench/double_ended_queue_unit_tb.sv @@
`timescale 1ns / 1ps

module double_ended_queue_unit_tb;
   import deq_pkg::*;

   // Kinds beyond pop back are spare codes: the block answers them with a plain ok
   localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
   localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;
   localparam int         CYCLE_LIMIT      = 1000000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   int mismatch_count;
   int words_outstanding;
   int words_checked;
   int words_sent;
   int cycle_count;
   int stall_left;
   int quiet_left;
   bit calm;

   double_ended_queue_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Watch both channels, predict and compare; the failure, outstanding and checked counts come back
   deque_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data          (req_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_data          (rsp_data),
      .mismatch_count    (mismatch_count),
      .words_outstanding (words_outstanding),
      .words_checked     (words_checked)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // Guard against a hung handshake
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL double_ended_queue_unit");
         $finish;
      end
   end

   // Result side: stall in random bursts, separated by
   // quiet stretches of varying length; hold stall low once calm is set
   always @(negedge clock) begin
      if (reset || calm) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
         quiet_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (quiet_left > 0) begin
         quiet_left--;
         rsp_stall <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
         stall_left = $urandom_range(1, 8) - 1;
         rsp_stall  <= 1'b1;
      end else begin
         quiet_left = $urandom_range(0, 24);
         rsp_stall  <= 1'b0;
      end
   end

   // Offer one request word and hold it until the block takes it.
   // Outside the calm tail, drop valid now and then for a random gap.
   task automatic offer_word(logic [2:0] kind, logic [31:0] value);
      int gap;
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 8);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid      <= 1'b1;
      req_data.kind  <= kind;
      req_data.value <= value;
      do @(posedge clock); while (req_stall);
      words_sent++;
   endtask

   // Choose an operation by percentage weights; the remainder goes to spare kinds
   function automatic logic [2:0] pick_kind(int push_pct, int list_pct, int pop_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < push_pct) begin
         return $urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
      end
      roll -= push_pct;
      if (roll < list_pct) begin
         return KIND_LIST_ALL;
      end
      roll -= list_pct;
      if (roll < pop_pct) begin
         return $urandom_range(0, 1) ? KIND_POP_FRONT : KIND_POP_BACK;
      end
      return 3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
   endfunction

   task automatic random_run(int count, int push_pct, int list_pct, int pop_pct);
      repeat (count) offer_word(pick_kind(push_pct, list_pct, pop_pct), $urandom());
   endtask

   task automatic wait_all_answered();
      while (words_outstanding != 0) @(posedge clock);
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      calm        = 1'b0;
      words_sent  = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty store: both pops and the list report empty
      offer_word(KIND_POP_FRONT, 32'h0000_0000);
      offer_word(KIND_POP_BACK, 32'hFFFF_FFFF);
      offer_word(KIND_LIST_ALL, 32'h0000_0000);
      // Extreme words from both ends, then list them in order
      offer_word(KIND_PUSH_BACK, 32'h7FFF_FFFF);
      offer_word(KIND_PUSH_BACK, 32'h8000_0000);
      offer_word(KIND_PUSH_FRONT, 32'h0000_0000);
      offer_word(KIND_PUSH_FRONT, 32'hFFFF_FFFF);
      offer_word(KIND_LIST_ALL, 32'hFFFF_FFFF);
      // Spare kinds leave the store alone
      offer_word(KIND_SPARE_FIRST, $urandom());
      offer_word(KIND_SPARE_FIRST + 3'd1, 32'h0000_0000);
      offer_word(KIND_SPARE_LAST, 32'hFFFF_FFFF);
      // Drain down to a pop from the back on a single entry, then pop back on the empty store
      offer_word(KIND_POP_FRONT, 32'h0000_0000);
      offer_word(KIND_POP_BACK, 32'h0000_0000);
      offer_word(KIND_POP_BACK, 32'h0000_0000);
      offer_word(KIND_POP_BACK, 32'h0000_0000);
      offer_word(KIND_POP_BACK, 32'h0000_0000);
      // Single entries from the other side
      offer_word(KIND_PUSH_FRONT, 32'h5555_5555);
      offer_word(KIND_POP_FRONT, 32'h0000_0000);
      offer_word(KIND_PUSH_BACK, 32'hAAAA_AAAA);
      offer_word(KIND_LIST_ALL, 32'h0000_0000);
      offer_word(KIND_POP_FRONT, 32'h0000_0000);

      // Hold the sender until every result of the directed part is in
      @(negedge clock);
      req_valid <= 1'b0;
      wait_all_answered();

      // Balanced mix, then fill well past full so pushes on a full store occur
      random_run(50, 45, 8, 40);
      random_run(80, 92, 4, 4);
      offer_word(KIND_LIST_ALL, $urandom());
      random_run(50, 40, 10, 40);
      // Drain past empty with both sides running flat out
      calm = 1'b1;
      random_run(80, 4, 4, 92);
      @(negedge clock);
      req_valid <= 1'b0;

      wait_all_answered();
      repeat (16) @(posedge clock);

      $display("Sent %0d request words (pushes, pops, lists, spare kinds, full and empty cases);",
               words_sent);
      $display("checked %0d result words with %0d mismatches.", words_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("PASS double_ended_queue_unit");
      end else begin
         $display("FAIL double_ended_queue_unit");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
sv/deq_pkg.sv
sv/deq_store.sv
sv/double_ended_queue_unit.sv
bench/deque_checker.sv
bench/double_ended_queue_unit_tb.sv
